// ===== hdl/estm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// estm_pkg
// Shared types, constants and arithmetic helpers of the object transform block.
// ----------------------------------------------------------------------------
package estm_pkg;

   localparam int ATAN_ENTRIES = 30;

   // arctan(2^-i) in Q30
   localparam logic [30:0] ATAN_Q30 [ATAN_ENTRIES] = '{
      31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
      31'd33543515,  31'd16775850,  31'd8388437,   31'd4194282,   31'd2097149,
      31'd1048575,   31'd524287,    31'd262143,    31'd131071,    31'd65535,
      31'd32767,     31'd16383,     31'd8191,      31'd4095,      31'd2047,
      31'd1023,      31'd511,       31'd255,       31'd127,       31'd63,
      31'd31,        31'd15,        31'd7,         31'd3,         31'd1
   };

   localparam logic [29:0] GAIN_INV = 30'd652032874;  // 1/K in Q30
   localparam logic [24:0] DEG2RAD  = 25'd18740330;   // pi/180 in Q30

   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] ROW_LAST = 2'd3;

   localparam logic signed [71:0] SAT_HI = 72'sd2147483647;
   localparam logic signed [71:0] SAT_LO = -72'sd2147483648;

   typedef logic signed [31:0] word_type;
   typedef logic signed [33:0] trig_type;

   typedef struct packed {
      word_type pos_x;
      word_type pos_y;
      word_type pos_z;
      word_type angle_x_deg;
      word_type angle_y_deg;
      word_type angle_z_deg;
      word_type scale_x;
      word_type scale_y;
      word_type scale_z;
   } req_type;

   typedef struct packed {
      word_type [2:0] p;
      word_type [2:0] s;
   } ps_type;

   typedef struct packed {
      trig_type [2:0][2:0] r;
      ps_type              ps;
   } xform_type;

   typedef struct packed {
      logic [1:0] row_index;
      word_type   col0;
      word_type   col1;
      word_type   col2;
      word_type   col3;
      logic       last_row;
   } row_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic word_type sat32(input logic signed [71:0] v);
      word_type res;
      if (v > SAT_HI) begin
         res = 32'sh7FFF_FFFF;
      end else if (v < SAT_LO) begin
         res = 32'sh8000_0000;
      end else begin
         res = word_type'(v[31:0]);
      end
      return res;
   endfunction

   // Q30 x Q30 -> Q30, round half up
   function automatic trig_type mul30(input trig_type a, input trig_type b);
      logic signed [67:0] prod;
      prod = 68'(a) * 68'(b);
      prod = prod + (68'sd1 <<< 29);
      return trig_type'(prod >>> 30);
   endfunction

   // number of quotient bits needed to reduce a 32-bit value by 360 << fb
   function automatic int quot_bits(input int fb);
      logic [63:0] full;
      int q;
      full = 64'd360 << fb;
      q = 0;
      for (int k = 0; k < 33; k++) begin
         if ((full << k) <= 64'hFFFF_FFFF) begin
            q = k + 1;
         end
      end
      return q;
   endfunction

endpackage

// ===== hdl/estm_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// estm interfaces
// Request and response channels of the object transform block.
// ----------------------------------------------------------------------------
interface estm_req_if;
   logic              valid;
   logic              ready;
   estm_pkg::word_type pos_x;
   estm_pkg::word_type pos_y;
   estm_pkg::word_type pos_z;
   estm_pkg::word_type angle_x_deg;
   estm_pkg::word_type angle_y_deg;
   estm_pkg::word_type angle_z_deg;
   estm_pkg::word_type scale_x;
   estm_pkg::word_type scale_y;
   estm_pkg::word_type scale_z;

   modport source (output valid, pos_x, pos_y, pos_z, angle_x_deg, angle_y_deg,
                   angle_z_deg, scale_x, scale_y, scale_z, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, angle_x_deg, angle_y_deg,
                 angle_z_deg, scale_x, scale_y, scale_z, output ready);
endinterface

interface estm_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        row_index;
   estm_pkg::word_type col0;
   estm_pkg::word_type col1;
   estm_pkg::word_type col2;
   estm_pkg::word_type col3;
   logic              last_row;

   modport source (output valid, row_index, col0, col1, col2, col3, last_row,
                   input ready);
   modport sink (input valid, row_index, col0, col1, col2, col3, last_row,
                 output ready);
endinterface

// ===== hdl/euler_scale_translate_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_scale_translate_matrix
// Object model matrix S*R*T from position, Euler angles and per-axis scale.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                   per request
//  req_ch    in    pos_xyz, angle_xyz_deg, scale_xyz (Q16.16) 1
//  rsp_ch    out   row_index, col0..col3, last_row            4 rows
//
// The back end emits one row per cycle while the receiver is ready, and the front
// can take a new request before the rows of the last one are out.
// Front and back stall independently; a two-entry queue sits between them.
// Reset is synchronous and clears valid bits, queue pointers and the row counter only.
// ----------------------------------------------------------------------------
module euler_scale_translate_matrix #(
   parameter int FRAC_BITS     = 16,
   parameter int CORDIC_STAGES = 24
) (
   input  logic       clock,
   input  logic       reset,
   estm_req_if.sink   req_ch,
   estm_rsp_if.source rsp_ch
);
   import estm_pkg::*;

   req_type   req;
   logic      f_valid, f_en, push, pop;
   xform_type f_xform, q_head;
   qstat_type q_stat;
   row_type   row;

   assign req.pos_x       = req_ch.pos_x;
   assign req.pos_y       = req_ch.pos_y;
   assign req.pos_z       = req_ch.pos_z;
   assign req.angle_x_deg = req_ch.angle_x_deg;
   assign req.angle_y_deg = req_ch.angle_y_deg;
   assign req.angle_z_deg = req_ch.angle_z_deg;
   assign req.scale_x     = req_ch.scale_x;
   assign req.scale_y     = req_ch.scale_y;
   assign req.scale_z     = req_ch.scale_z;

   // front stalls only when its last stage cannot drain into the queue
   assign f_en         = !(f_valid && q_stat.full);
   assign push         = f_valid && !q_stat.full;
   assign req_ch.ready = f_en;

   estm_front #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_front (
      .clock(clock), .reset(reset), .en(f_en), .in_valid(req_ch.valid),
      .in_req(req), .out_valid(f_valid), .out_xform(f_xform));

   estm_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(f_xform),
      .pop(pop), .pop_data(q_head), .status(q_stat));

   estm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .head(q_head), .qstat(q_stat), .pop(pop),
      .out_ready(rsp_ch.ready), .out_valid(rsp_ch.valid), .out_row(row));

   assign rsp_ch.row_index = row.row_index;
   assign rsp_ch.col0      = row.col0;
   assign rsp_ch.col1      = row.col1;
   assign rsp_ch.col2      = row.col2;
   assign rsp_ch.col3      = row.col3;
   assign rsp_ch.last_row  = row.last_row;

endmodule

// ===== hdl/estm_sincos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// estm_sincos
// One angle lane: modulo-360 reduction, quadrant fold, degree to radian
// scaling and a pipelined rotation-mode CORDIC.
// ----------------------------------------------------------------------------
module estm_sincos #(
   parameter int FRAC_BITS     = 16,
   parameter int CORDIC_STAGES = 24
) (
   input  logic               clock,
   input  logic               en,
   input  estm_pkg::word_type angle,
   output estm_pkg::trig_type sin_out,
   output estm_pkg::trig_type cos_out
);
   import estm_pkg::*;

   localparam int QB = quot_bits(FRAC_BITS);
   localparam int DW = FRAC_BITS + 8;
   localparam int PW = DW + 26;
   localparam logic [63:0] FULL = 64'd360 << FRAC_BITS;
   localparam logic [63:0] OFF  = 64'h8000_0000 % FULL;
   localparam logic signed [35:0] FULL_S = 36'(FULL);
   localparam logic signed [35:0] HALF_S = 36'(64'd180 << FRAC_BITS);
   localparam logic signed [35:0] QTR_S  = 36'(64'd90 << FRAC_BITS);
   localparam logic signed [35:0] OFF_S  = 36'(OFF);

   // remainder chain on angle + 2^31, one conditional subtract per stage
   logic [32:0] rem_ff [0:QB];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= 33'({~angle[31], angle[30:0]});
      end
   end

   for (genvar k = 1; k <= QB; k++) begin : g_rem
      localparam logic [63:0] STEP = FULL << (QB - k);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= (64'(rem_ff[k-1]) >= STEP) ? 33'(64'(rem_ff[k-1]) - STEP)
                                                     : rem_ff[k-1];
         end
      end
   end

   // fold into [-90, 90] degrees
   logic signed [35:0] d0, d1, d2, d3;
   logic               flip_in;
   logic signed [DW-1:0] fold_ff;
   logic               flip_fold_ff;

   always_comb begin
      d0 = signed'(36'(rem_ff[QB])) - OFF_S;
      d1 = (d0 < 0) ? d0 + FULL_S : d0;
      d2 = (d1 > HALF_S) ? d1 - FULL_S : d1;
      flip_in = 1'b0;
      d3 = d2;
      if (d2 > QTR_S) begin
         d3 = d2 - HALF_S;
         flip_in = 1'b1;
      end else if (d2 < -QTR_S) begin
         d3 = d2 + HALF_S;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fold_ff      <= DW'(d3);
         flip_fold_ff <= flip_in;
      end
   end

   // radians, Q30
   logic signed [PW-1:0] rad_prod;
   trig_type             z_in;

   always_comb begin
      rad_prod = PW'(fold_ff) * PW'(signed'({1'b0, DEG2RAD}));
      rad_prod = rad_prod + (PW'(1) <<< (FRAC_BITS - 1));
      z_in     = trig_type'(rad_prod >>> FRAC_BITS);
   end

   trig_type x_ff [0:CORDIC_STAGES];
   trig_type y_ff [0:CORDIC_STAGES];
   trig_type z_ff [0:CORDIC_STAGES];
   logic     fl_ff [0:CORDIC_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]  <= trig_type'(GAIN_INV);
         y_ff[0]  <= '0;
         z_ff[0]  <= z_in;
         fl_ff[0] <= flip_fold_ff;
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      localparam trig_type ATAN = trig_type'(ATAN_Q30[i]);
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][33]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN;
            end
            fl_ff[i+1] <= fl_ff[i];
         end
      end
   end

   trig_type sin_ff, cos_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= fl_ff[CORDIC_STAGES] ? -y_ff[CORDIC_STAGES] : y_ff[CORDIC_STAGES];
         cos_ff <= fl_ff[CORDIC_STAGES] ? -x_ff[CORDIC_STAGES] : x_ff[CORDIC_STAGES];
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

// ===== hdl/estm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// estm_front
// Front end: takes requests, runs three angle lanes and builds the rotation
// matrix Rz*Ry*Rx, with position and scale carried alongside.
// ----------------------------------------------------------------------------
module estm_front #(
   parameter int FRAC_BITS     = 16,
   parameter int CORDIC_STAGES = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  estm_pkg::req_type   in_req,
   output logic                out_valid,
   output estm_pkg::xform_type out_xform
);
   import estm_pkg::*;

   localparam int LL = quot_bits(FRAC_BITS) + CORDIC_STAGES + 4;  // lane latency
   localparam int FL = LL + 3;

   logic [FL-1:0] v_ff;
   ps_type        ps_ff [0:FL-1];
   ps_type        ps_in;

   assign ps_in.p = {in_req.pos_z, in_req.pos_y, in_req.pos_x};
   assign ps_in.s = {in_req.scale_z, in_req.scale_y, in_req.scale_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[FL-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ps_ff[0] <= ps_in;
         for (int k = 1; k < FL; k++) begin
            ps_ff[k] <= ps_ff[k-1];
         end
      end
   end

   trig_type sa, ca, sb, cb, sc, cc;

   estm_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lane_x (
      .clock(clock), .en(en), .angle(in_req.angle_x_deg), .sin_out(sa), .cos_out(ca));
   estm_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lane_y (
      .clock(clock), .en(en), .angle(in_req.angle_y_deg), .sin_out(sb), .cos_out(cb));
   estm_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lane_z (
      .clock(clock), .en(en), .angle(in_req.angle_z_deg), .sin_out(sc), .cos_out(cc));

   // first products
   trig_type cccb_ff, ccsb_ff, scca_ff, scsa_ff, sccb_ff, ccca_ff, sbsc_ff, ccsa_ff;
   trig_type cbsa_ff, cbca_ff, sa_ff, ca_ff, sb_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cccb_ff <= mul30(cc, cb);
         ccsb_ff <= mul30(cc, sb);
         scca_ff <= mul30(sc, ca);
         scsa_ff <= mul30(sc, sa);
         sccb_ff <= mul30(sc, cb);
         ccca_ff <= mul30(cc, ca);
         sbsc_ff <= mul30(sb, sc);
         ccsa_ff <= mul30(cc, sa);
         cbsa_ff <= mul30(cb, sa);
         cbca_ff <= mul30(cb, ca);
         sa_ff   <= sa;
         ca_ff   <= ca;
         sb_ff   <= sb;
      end
   end

   // second products
   trig_type t1_ff, t2_ff, t3_ff, t4_ff;
   trig_type b_cccb_ff, b_scca_ff, b_scsa_ff, b_sccb_ff, b_ccca_ff, b_ccsa_ff;
   trig_type b_cbsa_ff, b_cbca_ff, b_sb_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff     <= mul30(ccsb_ff, sa_ff);
         t2_ff     <= mul30(ccsb_ff, ca_ff);
         t3_ff     <= mul30(sbsc_ff, sa_ff);
         t4_ff     <= mul30(sbsc_ff, ca_ff);
         b_cccb_ff <= cccb_ff;
         b_scca_ff <= scca_ff;
         b_scsa_ff <= scsa_ff;
         b_sccb_ff <= sccb_ff;
         b_ccca_ff <= ccca_ff;
         b_ccsa_ff <= ccsa_ff;
         b_cbsa_ff <= cbsa_ff;
         b_cbca_ff <= cbca_ff;
         b_sb_ff   <= sb_ff;
      end
   end

   // matrix entries
   trig_type [2:0][2:0] r_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0][0] <= b_cccb_ff;
         r_ff[0][1] <= t1_ff - b_scca_ff;
         r_ff[0][2] <= b_scsa_ff + t2_ff;
         r_ff[1][0] <= b_sccb_ff;
         r_ff[1][1] <= b_ccca_ff + t3_ff;
         r_ff[1][2] <= t4_ff - b_ccsa_ff;
         r_ff[2][0] <= -b_sb_ff;
         r_ff[2][1] <= b_cbsa_ff;
         r_ff[2][2] <= b_cbca_ff;
      end
   end

   assign out_valid    = v_ff[FL-1];
   assign out_xform.r  = r_ff;
   assign out_xform.ps = ps_ff[FL-1];

endmodule

// ===== hdl/estm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// estm_queue
// Short queue of finished matrices between front and back end.
// ----------------------------------------------------------------------------
module estm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  estm_pkg::xform_type push_data,
   input  logic                pop,
   output estm_pkg::xform_type pop_data,
   output estm_pkg::qstat_type status
);
   import estm_pkg::*;

   localparam int QIDX = $clog2(QUEUE_DEPTH);

   xform_type       mem_ff [QUEUE_DEPTH];
   logic [QIDX-1:0] wr_ff, rd_ff;
   logic [QIDX:0]   cnt_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (32'(wr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (32'(rd_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (QIDX+1)'(push) - (QIDX+1)'(pop);
      end
   end

   assign pop_data     = mem_ff[rd_ff];
   assign status.full  = (32'(cnt_ff) == QUEUE_DEPTH);
   assign status.empty = (cnt_ff == '0);

endmodule

// ===== hdl/estm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// estm_back
// Back end: walks the rows of the queued matrix, applies scale and the
// translation dot product, and holds the response register.
// ----------------------------------------------------------------------------
module estm_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  estm_pkg::xform_type head,
   input  estm_pkg::qstat_type qstat,
   output logic                pop,
   input  logic                out_ready,
   output logic                out_valid,
   output estm_pkg::row_type   out_row
);
   import estm_pkg::*;

   logic en, issue;
   logic [1:0] row_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff;

   assign en    = !v4_ff || out_ready;
   assign issue = en && !qstat.empty;
   assign pop   = issue && (row_ff == ROW_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
      end else begin
         if (issue) begin
            row_ff <= row_ff + 2'd1;
         end
         if (en) begin
            v1_ff <= issue;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
         end
      end
   end

   // row select
   trig_type [2:0] r_sel;
   word_type       s_sel;

   always_comb begin
      case (row_ff)
         2'd0: begin
            r_sel = head.r[0];
            s_sel = head.ps.s[0];
         end
         2'd1: begin
            r_sel = head.r[1];
            s_sel = head.ps.s[1];
         end
         2'd2: begin
            r_sel = head.r[2];
            s_sel = head.ps.s[2];
         end
         default: begin
            r_sel = '0;
            s_sel = '0;
         end
      endcase
   end

   logic [1:0]     row1_ff;
   trig_type [2:0] r1_ff;
   word_type [2:0] p1_ff;
   word_type       s1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         row1_ff <= row_ff;
         r1_ff   <= r_sel;
         p1_ff   <= head.ps.p;
         s1_ff   <= s_sel;
      end
   end

   // scaled entries and per-column translation terms
   logic signed [65:0] cp [3];
   logic signed [65:0] mp [3];
   logic [1:0]         row2_ff;
   word_type [2:0]     c2_ff;
   logic signed [37:0] m2_ff [3];
   word_type           s2_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         cp[j] = 66'(s1_ff) * 66'(signed'(r1_ff[j]));
         cp[j] = cp[j] + (66'sd1 <<< 29);
         mp[j] = 66'(signed'(r1_ff[j])) * 66'(signed'(p1_ff[j]));
         mp[j] = mp[j] + (66'sd1 <<< 29);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         row2_ff <= row1_ff;
         s2_ff   <= s1_ff;
         for (int j = 0; j < 3; j++) begin
            c2_ff[j] <= sat32(72'(cp[j] >>> 30));
            m2_ff[j] <= 38'(mp[j] >>> 30);
         end
      end
   end

   logic [1:0]     row3_ff;
   word_type [2:0] c3_ff;
   word_type       s3_ff;
   word_type       dot3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         row3_ff <= row2_ff;
         c3_ff   <= c2_ff;
         s3_ff   <= s2_ff;
         dot3_ff <= sat32(72'(m2_ff[0]) + 72'(m2_ff[1]) + 72'(m2_ff[2]));
      end
   end

   logic signed [65:0] tp;
   row_type            row_in;
   row_type            out_ff;

   always_comb begin
      tp = 66'(s3_ff) * 66'(dot3_ff);
      tp = tp + (66'sd1 <<< (FRAC_BITS - 1));
      row_in.row_index = row3_ff;
      row_in.last_row  = (row3_ff == ROW_LAST);
      if (row3_ff == ROW_LAST) begin
         row_in.col0 = '0;
         row_in.col1 = '0;
         row_in.col2 = '0;
         row_in.col3 = word_type'(32'd1 << FRAC_BITS);
      end else begin
         row_in.col0 = signed'(c3_ff[0]);
         row_in.col1 = signed'(c3_ff[1]);
         row_in.col2 = signed'(c3_ff[2]);
         row_in.col3 = sat32(72'(tp >>> FRAC_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= row_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_row   = out_ff;

endmodule

// ===== hdl/estm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// estm_checker
// Port-level checks on the response stream of the transform block.
// ----------------------------------------------------------------------------
module estm_checker #(
   parameter int FRAC_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_row_index,
   input logic [31:0] rsp_col0,
   input logic [31:0] rsp_col1,
   input logic [31:0] rsp_col2,
   input logic [31:0] rsp_col3,
   input logic       rsp_last_row
);
   import estm_pkg::*;

   // nothing leaves right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_row == (rsp_row_index == ROW_LAST)))
      else $error("last_row flag does not match row index");

   a_row3_const: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_index == ROW_LAST |->
         rsp_col0 == 32'd0 && rsp_col1 == 32'd0 && rsp_col2 == 32'd0 &&
         rsp_col3 == (32'd1 << FRAC_BITS))
      else $error("bottom row is not 0 0 0 1");

   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_row ##1 rsp_valid |->
         rsp_row_index == $past(rsp_row_index) + 2'd1)
      else $error("rows out of order");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_index) &&
         $stable(rsp_col3))
      else $error("stalled response changed");

endmodule

bind euler_scale_translate_matrix estm_checker #(.FRAC_BITS(FRAC_BITS)) u_estm_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .rsp_row_index(rsp_ch.row_index), .rsp_col0(rsp_ch.col0), .rsp_col1(rsp_ch.col1),
   .rsp_col2(rsp_ch.col2), .rsp_col3(rsp_ch.col3), .rsp_last_row(rsp_ch.last_row));

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for euler_scale_translate_matrix: directed and random object
// transforms, four predicted matrix rows per request, random stalls both sides.
// ----------------------------------------------------------------------------
module tb;
   import estm_pkg::*;

   localparam int FB = 16;
   localparam int STAGES = 24;
   localparam longint LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   estm_req_if req_ch ();
   estm_rsp_if rsp_ch ();

   euler_scale_translate_matrix #(.FRAC_BITS(FB), .CORDIC_STAGES(STAGES)) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   row_type expected_rows[$];
   int      errors = 0;
   longint  cycles = 0;
   int      hold_off = 0;   // long receiver stall, counted down in its own process
   bit      stall_rand = 1'b1;

   // ---------------- predictor ----------------
   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_shr(longint v, int s);
      if (s == 0) return v;
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint q30_mul(longint a, longint b);
      return round_shr(a * b, 30);
   endfunction

   task automatic angle_trig(input word_type ang, output longint sn, output longint cs);
      longint full, half, quarter, d, x, y, z, dx, dy;
      bit flip;
      full = longint'(360) <<< FB;
      half = longint'(180) <<< FB;
      quarter = longint'(90) <<< FB;
      d = longint'(ang) % full;
      flip = 1'b0;
      if (d < 0) d += full;
      if (d > half) d -= full;
      if (d > quarter) begin
         d -= half;
         flip = 1'b1;
      end else if (d < -quarter) begin
         d += half;
         flip = 1'b1;
      end
      z = round_shr(d * longint'(DEG2RAD), FB);
      x = longint'(GAIN_INV);
      y = 0;
      for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      sn = y;
      cs = x;
   endtask

   task automatic predict_rows(input req_type t);
      longint sa, ca, sb, cb, sc, cc, dot;
      longint r[3][3];
      longint p[3], s[3], col[4];
      row_type row;
      p = '{longint'(t.pos_x), longint'(t.pos_y), longint'(t.pos_z)};
      s = '{longint'(t.scale_x), longint'(t.scale_y), longint'(t.scale_z)};
      angle_trig(t.angle_x_deg, sa, ca);
      angle_trig(t.angle_y_deg, sb, cb);
      angle_trig(t.angle_z_deg, sc, cc);
      r[0][0] = q30_mul(cc, cb);
      r[0][1] = q30_mul(q30_mul(cc, sb), sa) - q30_mul(sc, ca);
      r[0][2] = q30_mul(sc, sa) + q30_mul(q30_mul(cc, sb), ca);
      r[1][0] = q30_mul(sc, cb);
      r[1][1] = q30_mul(cc, ca) + q30_mul(q30_mul(sb, sc), sa);
      r[1][2] = q30_mul(q30_mul(sc, sb), ca) - q30_mul(cc, sa);
      r[2][0] = -sb;
      r[2][1] = q30_mul(cb, sa);
      r[2][2] = q30_mul(cb, ca);
      for (int i = 0; i < 3; i++) begin
         dot = 0;
         for (int j = 0; j < 3; j++) begin
            dot += round_shr(r[i][j] * p[j], 30);
            col[j] = clamp32(round_shr(s[i] * r[i][j], 30));
         end
         dot = clamp32(dot);
         col[3] = clamp32(round_shr(s[i] * dot, FB));
         row.row_index = 2'(i);
         row.col0 = word_type'(col[0]);
         row.col1 = word_type'(col[1]);
         row.col2 = word_type'(col[2]);
         row.col3 = word_type'(col[3]);
         row.last_row = 1'b0;
         expected_rows.insert(expected_rows.size(), row);
      end
      row.row_index = ROW_LAST;
      row.col0 = '0;
      row.col1 = '0;
      row.col2 = '0;
      row.col3 = word_type'(32'sd1 <<< FB);
      row.last_row = 1'b1;
      expected_rows.insert(expected_rows.size(), row);
   endtask

   // ---------------- sender ----------------
   int burst_left = 0;

   // valid stays high across a burst; it drops only for a gap or at the end of a test
   task automatic send_transform(input req_type t);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.pos_x <= t.pos_x;
      req_ch.pos_y <= t.pos_y;
      req_ch.pos_z <= t.pos_z;
      req_ch.angle_x_deg <= t.angle_x_deg;
      req_ch.angle_y_deg <= t.angle_y_deg;
      req_ch.angle_z_deg <= t.angle_z_deg;
      req_ch.scale_x <= t.scale_x;
      req_ch.scale_y <= t.scale_y;
      req_ch.scale_z <= t.scale_z;
      do @(posedge clock); while (!req_ch.ready);
      predict_rows(t);
   endtask

   task automatic stop_sending();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic word_type rand_word();
      return word_type'($urandom);
   endfunction

   function automatic word_type rand_angle();
      case ($urandom_range(0, 3))
         0: return word_type'($urandom);
         1: return word_type'(($urandom_range(0, 1440) - 720) <<< FB);
         2: return word_type'($urandom_range(0, 90 << FB) * ($urandom_range(0, 1) ? 1 : -1));
         default: return word_type'((int'($urandom_range(0, 8)) * 45 - 180) <<< FB);
      endcase
   endfunction

   function automatic word_type rand_scale();
      case ($urandom_range(0, 3))
         0: return word_type'($urandom);
         default: return word_type'(int'($urandom_range(0, 8 << FB)) - (4 << FB));
      endcase
   endfunction

   function automatic req_type rand_transform();
      req_type t;
      t.pos_x = $urandom_range(0, 3) == 0 ? rand_word() : word_type'($urandom_range(0, 1 << 22) - (1 << 21));
      t.pos_y = $urandom_range(0, 3) == 0 ? rand_word() : word_type'($urandom_range(0, 1 << 22) - (1 << 21));
      t.pos_z = $urandom_range(0, 3) == 0 ? rand_word() : word_type'($urandom_range(0, 1 << 22) - (1 << 21));
      t.angle_x_deg = rand_angle();
      t.angle_y_deg = rand_angle();
      t.angle_z_deg = rand_angle();
      t.scale_x = rand_scale();
      t.scale_y = rand_scale();
      t.scale_z = rand_scale();
      return t;
   endfunction

   function automatic req_type make_transform(word_type p, word_type a, word_type s);
      return '{p, p, p, a, a, a, s, s, s};
   endfunction

   // ---------------- receiver and checker ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ch.ready <= 1'b0;
      end else if (stall_rand) begin
         rsp_ch.ready <= (cycles % 23 < 5) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      row_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rows.size() == 0) begin
            errors++;
            $display("%0t: unexpected row %0d", $time, rsp_ch.row_index);
         end else begin
            want = expected_rows.pop_front();
            if (rsp_ch.row_index !== want.row_index || rsp_ch.col0 !== want.col0 ||
                rsp_ch.col1 !== want.col1 || rsp_ch.col2 !== want.col2 ||
                rsp_ch.col3 !== want.col3 || rsp_ch.last_row !== want.last_row) begin
               errors++;
               $display("%0t: mismatch exp row=%0d %0d %0d %0d %0d last=%0b",
                        $time, want.row_index, want.col0, want.col1, want.col2,
                        want.col3, want.last_row);
               $display("%0t:          got row=%0d %0d %0d %0d %0d last=%0b",
                        $time, rsp_ch.row_index, rsp_ch.col0, rsp_ch.col1,
                        rsp_ch.col2, rsp_ch.col3, rsp_ch.last_row);
            end
         end
      end
      if (cycles > LIMIT) begin
         $display("euler_scale_translate_matrix regression: fail");
         $finish;
      end
   end

   // ---------------- tests ----------------
   task automatic test_directed();
      word_type mx, mn, one;
      int wrap_deg[11] = '{90, -90, 180, -180, 270, 360, -360, 720, 91, -91, 181};
      mx = 32'sh7FFF_FFFF;
      mn = 32'sh8000_0000;
      one = 32'sd1 <<< FB;
      send_transform(make_transform('0, '0, one));
      send_transform(make_transform(mx, '0, mx));
      send_transform(make_transform(mn, '0, mn));
      send_transform(make_transform(mx, mx, mx));
      send_transform(make_transform(mn, mn, mn));
      send_transform(make_transform(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF));
      // quadrant edges and the wrap points of the angle reduction
      foreach (wrap_deg[i])
         send_transform(make_transform(one, word_type'(wrap_deg[i] <<< FB), one));
      for (int k = -4; k <= 8; k++)
         send_transform(make_transform(one, word_type'((k * 45) <<< FB), one));
      send_transform('{mx, mn, one, 32'sd1, -32'sd1, word_type'(179 <<< FB), mn, mx, -one});
      send_transform('{one, one, one, word_type'(90 <<< FB), word_type'(90 <<< FB),
                      word_type'(90 <<< FB), mx, mx, mx});
      stop_sending();
   endtask

   task automatic test_random(int n);
      repeat (n) send_transform(rand_transform());
      stop_sending();
   endtask

   task automatic test_backpressure();
      // receiver holds off long enough for the queue to fill and block requests
      @(posedge clock);
      hold_off <= 300;
      repeat (20) send_transform(rand_transform());
      stop_sending();
   endtask

   task automatic test_full_rate();
      stall_rand = 1'b0;
      burst_left = 60;
      repeat (30) send_transform(rand_transform());
      stop_sending();
      stall_rand = 1'b1;
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.pos_x = '0; req_ch.pos_y = '0; req_ch.pos_z = '0;
      req_ch.angle_x_deg = '0; req_ch.angle_y_deg = '0; req_ch.angle_z_deg = '0;
      req_ch.scale_x = '0; req_ch.scale_y = '0; req_ch.scale_z = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(50);
      test_backpressure();
      test_full_rate();
      test_random(30);
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("euler_scale_translate_matrix regression: pass");
      end else begin
         $display("euler_scale_translate_matrix regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/estm_pkg.sv
hdl/estm_ifs.sv
hdl/estm_sincos.sv
hdl/estm_front.sv
hdl/estm_queue.sv
hdl/estm_back.sv
hdl/euler_scale_translate_matrix.sv
hdl/estm_checker.sv
bench/tb.sv
